// ===== src/asvg_pkg.sv =====
package asvg_pkg;

  localparam int CordicGain   = 652032874;

  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_INNER_RADIUS = 3'd2,
    REG_OUTER_RADIUS = 3'd3,
    REG_START_ANGLE  = 3'd4,
    REG_END_ANGLE    = 3'd5,
    REG_SEGMENTS     = 3'd6,
    REG_FULL_DISK    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] ri;
    logic [15:0] ro;
    logic [16:0] u;
    logic        closing;
    logic        last;
  } side_t;

  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] t;
    begin
      unique case (k)
        0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
        3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
        6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
        9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
        12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
        15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
        18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
        21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
        default: t = 32'h0;
      endcase
      return t;
    end
  endfunction

endpackage

// ===== src/asvg_stream_if.sv =====
interface asvg_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== src/asvg_div_cell.sv =====
module asvg_div_cell #(
  parameter int QW = 17,
  parameter int DW = 16,
  parameter int PW = 28
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DW:0]          rem_in,
  input  logic [PW-1:0]        num_in,
  input  logic [DW-1:0]        den_in,
  input  logic [QW-1:0]        quo_in,
  output logic [DW:0]          rem_r,
  output logic [PW-1:0]        num_r,
  output logic [DW-1:0]        den_r,
  output logic [QW-1:0]        quo_r
);
  logic [DW+1:0] sh;
  logic [DW+1:0] diff;
  logic          ge;

  always_comb begin
    sh   = {rem_in, num_in[PW-1]};
    diff = sh - {2'b00, den_in};
    ge   = (sh >= {2'b00, den_in});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? diff[DW:0] : sh[DW:0];
      num_r <= {num_in[PW-2:0], 1'b0};
      den_r <= den_in;
      quo_r <= {quo_in[QW-2:0], ge};
    end
  end
endmodule

// ===== src/asvg_cordic_cell.sv =====
module asvg_cordic_cell #(
  parameter int K = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [33:0] x_in,
  input  logic signed [33:0] y_in,
  input  logic signed [33:0] z_in,
  output logic signed [33:0] x_r,
  output logic signed [33:0] y_r,
  output logic signed [33:0] z_r
);
  localparam logic signed [33:0] Atan = $signed({2'b00, asvg_pkg::atan_turn(K)});
  logic signed [33:0] xs, ys;

  always_comb begin
    xs = x_in >>> K;
    ys = y_in >>> K;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[33]) begin
        x_r <= x_in - ys;
        y_r <= y_in + xs;
        z_r <= z_in - Atan;
      end else begin
        x_r <= x_in + ys;
        y_r <= y_in - xs;
        z_r <= z_in + Atan;
      end
    end
  end
endmodule

// ===== src/arc_strip_vertex_generator.sv =====
// Streaming arc vertex generator: each transferred point index yields one inner/outer
// vertex pair with its u coordinate. One index is accepted every clock while the output
// is free or being taken. Each item passes through CORDIC_STAGES + 33 register stages:
// a chain of 28 restoring-divider cells (angle step and u run side by side), a stage that
// forms the vertex angle, the quadrant prerotation, the CORDIC_STAGES rotation cells,
// rounding, the radius multiply and the output register. The whole chain advances only
// while the output is free or being taken, so a waiting result holds the input off and
// stalls lose nothing.
module arc_strip_vertex_generator #(
  parameter int CORDIC_STAGES = 16,
  parameter int MAX_SEGMENTS  = 4095
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_point_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [17:0] out_inner_x,
  output logic signed [17:0] out_inner_y,
  output logic signed [17:0] out_outer_x,
  output logic signed [17:0] out_outer_y,
  output logic [16:0] out_tex_u,
  output logic        out_closing_pair,
  output logic        out_last_pair
);
  localparam int DivSteps = 29;
  localparam int Lat = DivSteps + 1 + CORDIC_STAGES + 3;
  localparam logic [11:0] MaxSeg = (MAX_SEGMENTS > 4095) ? 12'd4095 : 12'(MAX_SEGMENTS);

  logic [15:0] cx_r, cy_r, ri_r, ro_r, sa_r, ea_r;
  logic [11:0] seg_r;
  logic        fd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; ri_r <= '0; ro_r <= '0;
      sa_r <= '0; ea_r <= 16'd65208; seg_r <= 12'd100; fd_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (asvg_pkg::reg_idx_t'(cfg_index))
        asvg_pkg::REG_CENTER_X:     cx_r <= cfg_wdata;
        asvg_pkg::REG_CENTER_Y:     cy_r <= cfg_wdata;
        asvg_pkg::REG_INNER_RADIUS: ri_r <= cfg_wdata;
        asvg_pkg::REG_OUTER_RADIUS: ro_r <= cfg_wdata;
        asvg_pkg::REG_START_ANGLE:  sa_r <= cfg_wdata;
        asvg_pkg::REG_END_ANGLE:    ea_r <= cfg_wdata;
        asvg_pkg::REG_SEGMENTS: begin
          if (cfg_wdata[11:0] >= 12'd3)
            seg_r <= (cfg_wdata[11:0] > MaxSeg) ? MaxSeg : cfg_wdata[11:0];
        end
        asvg_pkg::REG_FULL_DISK:    fd_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic [Lat-1:0] vld_r;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[Lat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[Lat-2:0], in_valid};
  end

  // Front: clamp index, form the two dividends (span*i + n/2, i*65536 + n/2).
  logic [11:0] ic;
  logic [15:0] span;
  logic [27:0] numa, numb;
  logic        last_c, clos_c;
  always_comb begin
    ic     = (in_point_index > seg_r) ? seg_r : in_point_index;
    last_c = (ic == seg_r);
    clos_c = last_c && fd_r;
    span   = sa_r - ea_r;
    numa   = 28'(span) * 28'(ic) + 28'(seg_r[11:1]);
    numb   = {ic, 16'd0} + 28'(seg_r[11:1]);
  end

  logic [12:0] ra   [DivSteps];
  logic [27:0] na   [DivSteps];
  logic [11:0] da   [DivSteps];
  logic [16:0] qa   [DivSteps];
  logic [12:0] rb   [DivSteps];
  logic [27:0] nb   [DivSteps];
  logic [11:0] db   [DivSteps];
  logic [16:0] qb   [DivSteps];
  asvg_pkg::side_t sd [DivSteps+1];
  logic [15:0] sa_d [DivSteps+1];
  asvg_pkg::side_t sd_u;

  always_comb begin
    ra[0] = '0; na[0] = numa; da[0] = seg_r; qa[0] = '0;
    rb[0] = '0; nb[0] = numb; db[0] = seg_r; qb[0] = '0;
    sd[0] = '{cx: cx_r, cy: cy_r, ri: ri_r, ro: ro_r, u: '0,
              closing: clos_c, last: last_c};
    sa_d[0] = sa_r;
  end

  // 28 quotient bits; the stage after the chain forms the vertex angle and u.
  for (genvar g = 0; g < DivSteps - 1; g++) begin : g_div
    asvg_div_cell #(.QW(17), .DW(12), .PW(28)) u_a (
      .clk, .en(adv), .rem_in(ra[g]), .num_in(na[g]), .den_in(da[g]),
      .quo_in(qa[g]), .rem_r(ra[g+1]), .num_r(na[g+1]), .den_r(da[g+1]), .quo_r(qa[g+1]));
    asvg_div_cell #(.QW(17), .DW(12), .PW(28)) u_b (
      .clk, .en(adv), .rem_in(rb[g]), .num_in(nb[g]), .den_in(db[g]),
      .quo_in(qb[g]), .rem_r(rb[g+1]), .num_r(nb[g+1]), .den_r(db[g+1]), .quo_r(qb[g+1]));
    always_ff @(posedge clk) begin
      if (adv) begin
        sd[g+1] <= sd[g]; sa_d[g+1] <= sa_d[g];
      end
    end
  end

  always_comb begin
    sd_u   = sd[DivSteps-1];
    sd_u.u = sd[DivSteps-1].closing ? 17'h10000 : qb[DivSteps-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[DivSteps] <= sd_u;
      sa_d[DivSteps] <= sa_d[DivSteps-1] -
                        (sd[DivSteps-1].closing ? 16'd0 : qa[DivSteps-1][15:0]);
    end
  end

  // CORDIC prerotation into the right half-plane.
  logic signed [33:0] cxs [CORDIC_STAGES+1];
  logic signed [33:0] cys [CORDIC_STAGES+1];
  logic signed [33:0] czs [CORDIC_STAGES+1];
  asvg_pkg::side_t cs [CORDIC_STAGES+1];
  logic [31:0] a32;
  always_comb a32 = {sa_d[DivSteps], 16'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      cys[0] <= '0;
      cs[0]  <= sd[DivSteps];
      if (a32[31] ^ a32[30]) begin
        cxs[0] <= -(34'(asvg_pkg::CordicGain));
        czs[0] <= $signed({{2{a32[31] ^ 1'b1}}, a32 - 32'h80000000});
      end else begin
        cxs[0] <= 34'(asvg_pkg::CordicGain);
        czs[0] <= $signed({{2{a32[31]}}, a32});
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cor
    asvg_cordic_cell #(.K(k)) u_c (
      .clk, .en(adv), .x_in(cxs[k]), .y_in(cys[k]), .z_in(czs[k]),
      .x_r(cxs[k+1]), .y_r(cys[k+1]), .z_r(czs[k+1]));
    always_ff @(posedge clk) if (adv) cs[k+1] <= cs[k];
  end

  function automatic logic signed [16:0] q15(input logic signed [33:0] v);
    logic signed [33:0] r;
    begin
      r = (v + 34'sd16384) >>> 15;
      if (r > 34'sd32767) return 17'sd32767;
      if (r < -34'sd32768) return -17'sd32768;
      return 17'(r);
    end
  endfunction

  logic signed [16:0] c_r, s_r;
  asvg_pkg::side_t    q_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      c_r <= q15(cxs[CORDIC_STAGES]);
      s_r <= q15(cys[CORDIC_STAGES]);
      q_r <= cs[CORDIC_STAGES];
    end
  end

  logic signed [33:0] pic_r, pis_r, poc_r, pos_r;
  asvg_pkg::side_t    p_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pic_r <= $signed({1'b0, q_r.ri}) * c_r;
      pis_r <= $signed({1'b0, q_r.ri}) * s_r;
      poc_r <= $signed({1'b0, q_r.ro}) * c_r;
      pos_r <= $signed({1'b0, q_r.ro}) * s_r;
      p_r   <= q_r;
    end
  end

  function automatic logic [17:0] rnd(input logic signed [33:0] v);
    logic signed [33:0] r;
    begin
      r = (v + 34'sd16384) >>> 15;
      return r[17:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      out_inner_x      <= $signed({2'b00, p_r.cx} + rnd(pic_r));
      out_inner_y      <= $signed({2'b00, p_r.cy} - rnd(pis_r));
      out_outer_x      <= $signed({2'b00, p_r.cx} + rnd(poc_r));
      out_outer_y      <= $signed({2'b00, p_r.cy} - rnd(pos_r));
      out_tex_u        <= p_r.u;
      out_closing_pair <= p_r.closing;
      out_last_pair    <= p_r.last;
    end
  end
endmodule

// ===== test/arc_strip_vertex_generator_test.sv =====
module arc_strip_vertex_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Stages     = 16;
  localparam int CycleLimit = 900000;

  typedef struct {
    logic signed [17:0] inner_x;
    logic signed [17:0] inner_y;
    logic signed [17:0] outer_x;
    logic signed [17:0] outer_y;
    logic [16:0]        tex_u;
    logic               closing;
    logic               last;
  } vertex_pair_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  asvg_pkg::reg_idx_t cfg_index = asvg_pkg::REG_CENTER_X;
  logic [15:0] cfg_wdata = '0;

  asvg_stream_if #(.W(12)) point_if ();
  asvg_stream_if #(.W(91)) vertex_if ();

  logic signed [17:0] o_ix, o_iy, o_ox, o_oy;
  logic [16:0]        o_u;
  logic               o_cl, o_la;

  assign vertex_if.data = {o_ix, o_iy, o_ox, o_oy, o_u, o_cl, o_la};

  arc_strip_vertex_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (point_if.valid),
    .in_ready         (point_if.ready),
    .in_point_index   (point_if.data),
    .out_valid        (vertex_if.valid),
    .out_ready        (vertex_if.ready),
    .out_inner_x      (o_ix),
    .out_inner_y      (o_iy),
    .out_outer_x      (o_ox),
    .out_outer_y      (o_oy),
    .out_tex_u        (o_u),
    .out_closing_pair (o_cl),
    .out_last_pair    (o_la)
  );

  // Shadow copy of the configuration registers.
  int unsigned arc_cx = 0, arc_cy = 0, arc_ri = 0, arc_ro = 0;
  int unsigned arc_start = 0, arc_end = 65208, arc_segments = 100, arc_full = 0;

  logic [11:0]  pending_points[$];
  vertex_pair_t expected_pairs[$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           sender_no_gaps = 0;
  bit           receiver_no_stalls = 0;
  int           hold_requests = 0;
  int           hold_served = 0;
  int           send_gap = 0;
  int           stall_left = 0;

  always #5 clk = ~clk;

  function automatic longint to_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic void rotate(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a;
    longint      x, y, z, t;
    a = {ang, 16'h0000};
    x = asvg_pkg::CordicGain;
    y = 0;
    if (a[31:30] == 2'd1 || a[31:30] == 2'd2) begin
      x = -x;
      a = a - 32'h80000000;
    end
    z = longint'($signed(a));
    for (int k = 0; k < Stages; k++) begin
      if (z >= 0) begin
        t = x - (y >>> k);
        y = y + (x >>> k);
        z = z - longint'(asvg_pkg::atan_turn(k));
      end else begin
        t = x + (y >>> k);
        y = y - (x >>> k);
        z = z + longint'(asvg_pkg::atan_turn(k));
      end
      x = t;
    end
    c = to_q15(x);
    s = to_q15(y);
  endfunction

  function automatic vertex_pair_t predict_pair(logic [11:0] index);
    vertex_pair_t p;
    longint       n, i, span, delta, c, s;
    logic [15:0]  ang;
    bit           last, closing;
    n = arc_segments;
    i = index;
    if (i > n) i = n;
    last = (i == n);
    closing = last && arc_full != 0;
    span = (arc_start - arc_end) & 16'hFFFF;
    delta = closing ? 0 : (span * i + n / 2) / n;
    ang = 16'((arc_start - delta) & 16'hFFFF);
    rotate(ang, c, s);
    p.inner_x = 18'(longint'(arc_cx) + ((longint'(arc_ri) * c + 16384) >>> 15));
    p.inner_y = 18'(longint'(arc_cy) - ((longint'(arc_ri) * s + 16384) >>> 15));
    p.outer_x = 18'(longint'(arc_cx) + ((longint'(arc_ro) * c + 16384) >>> 15));
    p.outer_y = 18'(longint'(arc_cy) - ((longint'(arc_ro) * s + 16384) >>> 15));
    p.tex_u   = closing ? 17'd65536 : 17'((i * 65536 + n / 2) / n);
    p.closing = closing;
    p.last    = last;
    return p;
  endfunction

  function automatic int pick_gap(bit none);
    int r;
    r = $urandom_range(0, 19);
    if (none || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch in %s: got %0d, expected %0d", field, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      point_if.valid <= 1'b0;
      point_if.data <= '0;
      send_gap = 0;
    end else begin
      if (point_if.valid && point_if.ready) expected_pairs.push_back(predict_pair(point_if.data));
      if (!point_if.valid || point_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          point_if.valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          point_if.valid <= 1'b1;
          point_if.data <= pending_points.pop_front();
          send_gap = pick_gap(sender_no_gaps);
        end else begin
          point_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    vertex_pair_t w;
    if (!rst_n) begin
      vertex_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (vertex_if.valid && vertex_if.ready) begin
        if (expected_pairs.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          w = expected_pairs.pop_front();
          if (o_ix !== w.inner_x) report_mismatch("inner_x", o_ix, w.inner_x);
          if (o_iy !== w.inner_y) report_mismatch("inner_y", o_iy, w.inner_y);
          if (o_ox !== w.outer_x) report_mismatch("outer_x", o_ox, w.outer_x);
          if (o_oy !== w.outer_y) report_mismatch("outer_y", o_oy, w.outer_y);
          if (o_u !== w.tex_u) report_mismatch("tex_u", o_u, w.tex_u);
          if (o_cl !== w.closing) report_mismatch("closing_pair", o_cl, w.closing);
          if (o_la !== w.last) report_mismatch("last_pair", o_la, w.last);
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        vertex_if.ready <= 1'b0;
      end else if (vertex_if.valid && !vertex_if.ready) begin
        vertex_if.ready <= 1'b1;
      end else begin
        stall_left = pick_gap(receiver_no_stalls);
        vertex_if.ready <= (stall_left == 0);
      end
    end
  end

  task automatic write_reg(asvg_pkg::reg_idx_t idx, logic [15:0] value);
    int unsigned n;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    unique case (idx)
      asvg_pkg::REG_CENTER_X:     arc_cx = value;
      asvg_pkg::REG_CENTER_Y:     arc_cy = value;
      asvg_pkg::REG_INNER_RADIUS: arc_ri = value;
      asvg_pkg::REG_OUTER_RADIUS: arc_ro = value;
      asvg_pkg::REG_START_ANGLE:  arc_start = value;
      asvg_pkg::REG_END_ANGLE:    arc_end = value;
      asvg_pkg::REG_SEGMENTS: begin
        n = value[11:0];
        if (n >= 3) arc_segments = n;
      end
      asvg_pkg::REG_FULL_DISK:    arc_full = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    while (pending_points.size() > 0 || point_if.valid || expected_pairs.size() > 0)
      @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic queue_points(int count);
    int r;
    @(negedge clk);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 19);
      if (r < 15) pending_points.push_back(12'($urandom_range(0, arc_segments)));
      else if (r < 17) pending_points.push_back(12'(arc_segments));
      else if (r < 18) pending_points.push_back(12'd0);
      else pending_points.push_back(12'($urandom_range(0, 4095)));
    end
  endtask

  function automatic logic [15:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic random_config();
    int r;
    write_reg(asvg_pkg::REG_CENTER_X, pick_value());
    write_reg(asvg_pkg::REG_CENTER_Y, pick_value());
    write_reg(asvg_pkg::REG_INNER_RADIUS, pick_value());
    write_reg(asvg_pkg::REG_OUTER_RADIUS, pick_value());
    write_reg(asvg_pkg::REG_START_ANGLE, pick_value());
    if ($urandom_range(0, 7) == 0) write_reg(asvg_pkg::REG_END_ANGLE, 16'(arc_start));
    else write_reg(asvg_pkg::REG_END_ANGLE, pick_value());
    r = $urandom_range(0, 9);
    if (r == 0) write_reg(asvg_pkg::REG_SEGMENTS, 16'd3);
    else if (r == 1) write_reg(asvg_pkg::REG_SEGMENTS, 16'd4095);
    else if (r == 2)
      write_reg(asvg_pkg::REG_SEGMENTS,
                16'($urandom_range(0, 2) | ($urandom_range(0, 15) << 12)));
    else if (r < 7) write_reg(asvg_pkg::REG_SEGMENTS, 16'($urandom_range(3, 64)));
    else write_reg(asvg_pkg::REG_SEGMENTS, 16'($urandom_range(0, 65535)));
    write_reg(asvg_pkg::REG_FULL_DISK, 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    pending_points.push_back(12'd0);
    pending_points.push_back(12'd50);
    pending_points.push_back(12'd100);
    pending_points.push_back(12'd101);
    pending_points.push_back(12'd4095);
    drain();

    write_reg(asvg_pkg::REG_CENTER_X, 16'hFFFF);
    write_reg(asvg_pkg::REG_CENTER_Y, 16'hFFFF);
    write_reg(asvg_pkg::REG_INNER_RADIUS, 16'hFFFF);
    write_reg(asvg_pkg::REG_OUTER_RADIUS, 16'h0000);
    write_reg(asvg_pkg::REG_START_ANGLE, 16'h0000);
    write_reg(asvg_pkg::REG_END_ANGLE, 16'h0000);
    write_reg(asvg_pkg::REG_SEGMENTS, 16'd3);
    write_reg(asvg_pkg::REG_FULL_DISK, 16'd1);
    @(negedge clk);
    for (int k = 0; k < 4; k++) pending_points.push_back(12'(k));
    pending_points.push_back(12'd4095);
    drain();

    write_reg(asvg_pkg::REG_CENTER_X, 16'h0000);
    write_reg(asvg_pkg::REG_CENTER_Y, 16'h0000);
    write_reg(asvg_pkg::REG_INNER_RADIUS, 16'h0000);
    write_reg(asvg_pkg::REG_OUTER_RADIUS, 16'hFFFF);
    write_reg(asvg_pkg::REG_START_ANGLE, 16'h4000);
    write_reg(asvg_pkg::REG_END_ANGLE, 16'hC000);
    write_reg(asvg_pkg::REG_SEGMENTS, 16'd4095);
    write_reg(asvg_pkg::REG_SEGMENTS, 16'd2);
    write_reg(asvg_pkg::REG_FULL_DISK, 16'd0);
    @(negedge clk);
    pending_points.push_back(12'd0);
    pending_points.push_back(12'd1);
    pending_points.push_back(12'd1024);
    pending_points.push_back(12'd2047);
    pending_points.push_back(12'd3072);
    pending_points.push_back(12'd4094);
    pending_points.push_back(12'd4095);
    drain();

    for (int phase = 0; phase < 16; phase++) begin
      random_config();
      sender_no_gaps = (phase % 4 == 1) || (phase == 5);
      receiver_no_stalls = (phase % 4 == 2);
      if (phase == 5) hold_requests <= hold_requests + 1;
      queue_points(114);
      drain();
    end

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
